>>> rtl/btnrep_pkg.sv
// Shared types and constants for the button edge and auto-repeat unit.
package btnrep_pkg;

   // Default configuration of the unit
   localparam int PAD_COUNT_DEF     = 16;
   localparam int REPEAT_PERIOD_DEF = 4;
   localparam int BUTTONS_DEF       = 32;

   // Field widths
   localparam int PAD_W    = 4;
   localparam int WORD_W   = 32;
   localparam int SEL_W    = 5;
   localparam int DELAY_W  = 8;
   localparam int COUNT_W  = 16;

   // Hold counter saturation value, which ends repeating
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Reset value of the first_delay register
   localparam logic [DELAY_W-1:0] FIRST_DELAY_RESET = 8'd17;

   // One frame sample for one pad
   typedef struct packed {
      logic [PAD_W-1:0]  pad_index;
      logic [WORD_W-1:0] buttons;
      logic              window_active;
      logic [SEL_W-1:0]  button_select;
   } req_type;

   // One result per frame sample
   typedef struct packed {
      logic [PAD_W-1:0]   pad_out;
      logic [WORD_W-1:0]  pressed;
      logic [WORD_W-1:0]  newly_down;
      logic [WORD_W-1:0]  repeat_hit;
      logic [COUNT_W-1:0] selected_count;
   } rsp_type;

endpackage

>>> rtl/button_edge_and_autorepeat_unit.sv
// Top level: per-pad edge detect and typematic auto-repeat over a row memory.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   req     | in        | req_valid / req_ready | btnrep_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_ready | btnrep_pkg::rsp_type
//   csr     | in        | csr_write_en          | csr_write_data (first_delay)
//
// One item per cycle while no result stalls; the row is read at the transfer, then the
// counters are updated and written back, then the reciprocal multiply and the remainder.
// Each pad owns one memory row: its previous word plus all hold counters.
// A row written in the cycle its next sample is read is forwarded.
// Reset clears the per-row valid bits at once; there is no clearing pass.
// A stalled result holds the whole pipeline and drops req_ready.
module button_edge_and_autorepeat_unit #(
   parameter int PAD_COUNT       = btnrep_pkg::PAD_COUNT_DEF,
   parameter int REPEAT_PERIOD   = btnrep_pkg::REPEAT_PERIOD_DEF,
   parameter int BUTTONS_PER_PAD = btnrep_pkg::BUTTONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  btnrep_pkg::req_type               req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output btnrep_pkg::rsp_type               rsp_data,
   input  logic                              csr_write_en,
   input  logic [btnrep_pkg::DELAY_W-1:0]    csr_write_data
);
   import btnrep_pkg::*;

   localparam int NB          = BUTTONS_PER_PAD;
   localparam int ADDR_W      = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
   localparam int ROW_W       = NB + NB * COUNT_W;
   localparam int RECIP_SHIFT = COUNT_W + $clog2(REPEAT_PERIOD);
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = COUNT_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MUL =
      RECIP_W'(((1 << RECIP_SHIFT) + REPEAT_PERIOD - 1) / REPEAT_PERIOD);

   // Row memory and its valid bits
   logic [ROW_W-1:0]     row_mem [PAD_COUNT];
   logic [PAD_COUNT-1:0] row_vld_ff;
   logic [ROW_W-1:0]     row_q_ff;

   logic [DELAY_W-1:0]   first_delay_ff;

   // Pipeline control
   logic adv;
   logic accept;
   logic req_inrange;
   logic [ADDR_W-1:0] req_addr;
   logic [NB-1:0]     req_now;
   logic wr_en;

   // Stage 1: row read result
   logic              s1_valid_ff;
   logic              s1_inrange_ff;
   logic              s1_rowvld_ff;
   logic              s1_fwd_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [PAD_W-1:0]  s1_pad_ff;
   logic [SEL_W-1:0]  s1_sel_ff;
   logic [NB-1:0]     s1_now_ff;
   logic [ROW_W-1:0]  fwd_row_ff;

   logic [ROW_W-1:0]   cur_row;
   logic [ROW_W-1:0]   new_row;
   logic [NB-1:0]      s1_edges;
   logic [COUNT_W-1:0] c_new [NB];
   logic [COUNT_W-1:0] s1_d [NB];
   logic [NB-1:0]      s1_above;
   logic [NB-1:0]      s1_one;
   logic [NB-1:0]      s1_sat;
   logic [COUNT_W-1:0] s1_sel_count;

   // Stage 2: updated counts
   logic               s2_valid_ff;
   logic [PAD_W-1:0]   s2_pad_ff;
   logic [NB-1:0]      s2_now_ff;
   logic [NB-1:0]      s2_edges_ff;
   logic [COUNT_W-1:0] s2_sel_count_ff;
   logic [COUNT_W-1:0] s2_d_ff [NB];
   logic [NB-1:0]      s2_above_ff;
   logic [NB-1:0]      s2_one_ff;
   logic [NB-1:0]      s2_sat_ff;
   logic [COUNT_W-1:0] s2_q [NB];

   // Stage 3: quotients
   logic               s3_valid_ff;
   logic [PAD_W-1:0]   s3_pad_ff;
   logic [NB-1:0]      s3_now_ff;
   logic [NB-1:0]      s3_edges_ff;
   logic [COUNT_W-1:0] s3_sel_count_ff;
   logic [COUNT_W-1:0] s3_d_ff [NB];
   logic [COUNT_W-1:0] s3_q_ff [NB];
   logic [NB-1:0]      s3_above_ff;
   logic [NB-1:0]      s3_one_ff;
   logic [NB-1:0]      s3_sat_ff;
   logic [WORD_W-1:0]  s3_hits;

   // Output register
   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type out_data_in;

   // Advance the whole pipeline unless a result is stalled
   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Gate the sample by window and pad range, keep the low buttons
   assign req_addr    = ADDR_W'(req_data.pad_index);
   assign req_inrange = int'(req_data.pad_index) < PAD_COUNT;
   assign req_now     = (req_data.window_active && req_inrange) ?
                        req_data.buttons[NB-1:0] : '0;
   assign wr_en       = adv && s1_valid_ff && s1_inrange_ff;

   // Update the row: edges, saturating counters, repeat terms
   always_comb begin
      logic [COUNT_W-1:0] c_old;
      cur_row = s1_fwd_ff ? fwd_row_ff : (s1_rowvld_ff ? row_q_ff : '0);
      s1_edges = s1_inrange_ff ? (s1_now_ff & ~cur_row[NB-1:0]) : '0;
      new_row = '0;
      new_row[NB-1:0] = s1_now_ff;
      s1_sel_count = '0;
      for (int b = 0; b < NB; b++) begin
         c_old = cur_row[NB + b * COUNT_W +: COUNT_W];
         if (!s1_now_ff[b]) begin
            c_new[b] = '0;
         end else if (c_old == COUNT_MAX) begin
            c_new[b] = COUNT_MAX;
         end else begin
            c_new[b] = COUNT_W'(c_old + 1'b1);
         end
         new_row[NB + b * COUNT_W +: COUNT_W] = c_new[b];
         s1_above[b] = c_new[b] > COUNT_W'(first_delay_ff);
         s1_d[b]     = COUNT_W'(c_new[b] - COUNT_W'(first_delay_ff));
         s1_one[b]   = c_new[b] == COUNT_W'(1);
         s1_sat[b]   = c_new[b] == COUNT_MAX;
         if (int'(s1_sel_ff) == b) begin
            s1_sel_count = c_new[b];
         end
      end
   end

   // Quotient of the repeat offset by the period, via reciprocal
   always_comb begin
      logic [PROD_W-1:0] prod;
      for (int b = 0; b < NB; b++) begin
         prod    = PROD_W'(s2_d_ff[b]) * PROD_W'(RECIP_MUL);
         s2_q[b] = prod[RECIP_SHIFT +: COUNT_W];
      end
   end

   // Remainder and hit decision
   always_comb begin
      logic [COUNT_W-1:0] rem;
      s3_hits = '0;
      for (int b = 0; b < NB; b++) begin
         rem = COUNT_W'(s3_d_ff[b] - COUNT_W'(s3_q_ff[b] * COUNT_W'(REPEAT_PERIOD)));
         s3_hits[b] = !s3_sat_ff[b] &&
                      (s3_above_ff[b] ? (rem == COUNT_W'(1)) : s3_one_ff[b]);
      end
      out_data_in.pad_out        = s3_pad_ff;
      out_data_in.pressed        = WORD_W'(s3_now_ff);
      out_data_in.newly_down     = WORD_W'(s3_edges_ff);
      out_data_in.repeat_hit     = s3_hits;
      out_data_in.selected_count = s3_sel_count_ff;
   end

   // Read and write back pad rows
   always_ff @(posedge clock) begin
      if (accept && req_inrange) begin
         row_q_ff <= row_mem[req_addr];
      end
      if (wr_en) begin
         row_mem[s1_addr_ff] <= new_row;
      end
   end

   // Control state: valids, forwarding flag, row valid bits, register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         s1_fwd_ff      <= 1'b0;
         row_vld_ff     <= '0;
         first_delay_ff <= FIRST_DELAY_RESET;
      end else begin
         if (csr_write_en) begin
            first_delay_ff <= csr_write_data;
         end
         if (adv) begin
            s1_valid_ff  <= req_valid;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            out_valid_ff <= s3_valid_ff;
            s1_fwd_ff    <= accept && req_inrange && wr_en && (req_addr == s1_addr_ff);
         end
         if (wr_en) begin
            row_vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_row_ff <= new_row;
      end
      if (adv) begin
         s1_inrange_ff   <= req_inrange;
         s1_rowvld_ff    <= req_inrange && row_vld_ff[req_addr];
         s1_addr_ff      <= req_addr;
         s1_pad_ff       <= req_data.pad_index;
         s1_sel_ff       <= req_data.button_select;
         s1_now_ff       <= req_now;

         s2_pad_ff       <= s1_pad_ff;
         s2_now_ff       <= s1_now_ff;
         s2_edges_ff     <= s1_edges;
         s2_sel_count_ff <= s1_sel_count;
         s2_d_ff         <= s1_d;
         s2_above_ff     <= s1_above;
         s2_one_ff       <= s1_one;
         s2_sat_ff       <= s1_sat;

         s3_pad_ff       <= s2_pad_ff;
         s3_now_ff       <= s2_now_ff;
         s3_edges_ff     <= s2_edges_ff;
         s3_sel_count_ff <= s2_sel_count_ff;
         s3_d_ff         <= s2_d_ff;
         s3_q_ff         <= s2_q;
         s3_above_ff     <= s2_above_ff;
         s3_one_ff       <= s2_one_ff;
         s3_sat_ff       <= s2_sat_ff;

         out_data_ff     <= out_data_in;
      end
   end

   // A forwarded row always comes from the same pad one item earlier
   a_fwd_same_pad: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> (s1_valid_ff && s1_addr_ff == $past(s1_addr_ff)))
      else $error("forwarded row does not match pad");

   // Edges and hits only on held buttons
   a_bits_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_data.newly_down | rsp_data.repeat_hit)
                      & ~rsp_data.pressed) == '0))
      else $error("edge or hit on a released button");

   // A new press starts its counter at one, which hits unless the period is one
   a_press_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((REPEAT_PERIOD == 1) ||
                     ((rsp_data.newly_down & ~rsp_data.repeat_hit) == '0)))
      else $error("previous word and hold counters out of step");

   // A pad outside the range reports nothing
   a_pad_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && int'(rsp_data.pad_out) >= PAD_COUNT) |->
      (rsp_data.pressed == '0 && rsp_data.selected_count == '0))
      else $error("out-of-range pad produced data");

endmodule

>>> sim/tb_button_edge_and_autorepeat_unit.sv
// Self-checking testbench for the button edge detect and auto-repeat unit.
module tb_button_edge_and_autorepeat_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import btnrep_pkg::*;

   localparam int PADS    = PAD_COUNT_DEF;
   localparam int PERIOD  = REPEAT_PERIOD_DEF;
   localparam int BUTTONS = BUTTONS_DEF;
   localparam logic [WORD_W-1:0] BUTTON_MASK = {WORD_W{1'b1}} >> (WORD_W - BUTTONS);

   // Tracks per-pad button history and hold counts, queues the expected results
   class typematic_tracker;
      logic [WORD_W-1:0]  last_word [PADS];
      logic [COUNT_W-1:0] hold_count [PADS][BUTTONS];
      logic [DELAY_W-1:0] first_delay;
      rsp_type            pending_q [$];
      int                 mismatch_count;

      function new();
         foreach (last_word[p]) last_word[p] = '0;
         foreach (hold_count[p, b]) hold_count[p][b] = '0;
         first_delay    = FIRST_DELAY_RESET;
         mismatch_count = 0;
      endfunction

      // Hit at count 1, then first_delay+1 and every PERIOD after; none once saturated
      function bit repeat_due(int unsigned count);
         int unsigned phase = count;
         if (count >= COUNT_MAX) return 1'b0;
         if (count > first_delay) phase = (count - first_delay) % PERIOD;
         return phase == 1;
      endfunction

      // Advance the pad state for one accepted frame and queue its result
      function void note_frame(req_type item);
         rsp_type           want;
         logic [WORD_W-1:0] now;
         int unsigned       c;
         want         = '0;
         want.pad_out = item.pad_index;
         if (item.pad_index < PADS) begin
            now             = item.window_active ? (item.buttons & BUTTON_MASK) : '0;
            want.pressed    = now;
            want.newly_down = now & ~last_word[item.pad_index];
            last_word[item.pad_index] = now;
            for (int b = 0; b < BUTTONS; b++) begin
               c = hold_count[item.pad_index][b];
               if (now[b]) begin
                  if (c < COUNT_MAX) c++;
               end else begin
                  c = 0;
               end
               hold_count[item.pad_index][b] = COUNT_W'(c);
               want.repeat_hit[b] = repeat_due(c);
               if (b == item.button_select) want.selected_count = COUNT_W'(c);
            end
         end
         pending_q.push_back(want);
      endfunction

      function void compare_field(string name, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
         end
      endfunction

      // Match one result against the oldest expectation
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            $error("result with nothing expected: %h", got);
            mismatch_count++;
            return;
         end
         want = pending_q.pop_front();
         compare_field("pad_out", WORD_W'(want.pad_out), WORD_W'(got.pad_out));
         compare_field("pressed", want.pressed, got.pressed);
         compare_field("newly_down", want.newly_down, got.newly_down);
         compare_field("repeat_hit", want.repeat_hit, got.repeat_hit);
         compare_field("selected_count", WORD_W'(want.selected_count),
                       WORD_W'(got.selected_count));
      endfunction
   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   req_type             req_data       = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_en   = 1'b0;
   logic [DELAY_W-1:0]  csr_write_data = '0;

   typematic_tracker    tracker = new();
   logic [WORD_W-1:0]   held_word [PADS] = '{default: '0};
   int unsigned         req_idle_pct = 36;
   int unsigned         rsp_idle_pct = 36;

   always #2 clock = ~clock;

   button_edge_and_autorepeat_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   function automatic req_type frame(int unsigned pad, logic [WORD_W-1:0] word,
                                     bit active, int unsigned sel);
      req_type item;
      item.pad_index     = PAD_W'(pad);
      item.buttons       = word;
      item.window_active = active;
      item.button_select = SEL_W'(sel);
      return item;
   endfunction

   // Offer one frame, with random idle cycles first, and hold it until the transfer
   task automatic send_frame(req_type item);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_frame(item);
   endtask

   // Drop valid and wait until every expected result has come out
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_first_delay(logic [DELAY_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      tracker.first_delay = value;
   endtask

   // Mostly held patterns per pad with random content; churn sets the rate of
   // new patterns, single presses and releases, one-frame glitches and focus loss
   task automatic run_random(int unsigned count, int unsigned pad_top, int unsigned churn);
      req_type     item;
      int unsigned roll;
      repeat (count) begin
         roll               = $urandom_range(0, 99);
         item.pad_index     = PAD_W'($urandom_range(0, pad_top));
         item.button_select = SEL_W'($urandom());
         item.window_active = 1'b1;
         if (roll < churn)
            held_word[item.pad_index] = $urandom();
         else if (roll < 4 * churn)
            held_word[item.pad_index] ^= WORD_W'(1) << $urandom_range(0, WORD_W - 1);
         item.buttons = held_word[item.pad_index];
         if (roll >= 4 * churn && roll < 5 * churn) begin
            item.buttons = $urandom();
         end else if (roll >= 5 * churn && roll < 6 * churn) begin
            item.window_active = 1'b0;
            item.buttons       = $urandom();
         end
         send_frame(item);
      end
   endtask

   // Result side: random stalls, one long hold-off to back up the pipeline
   initial begin : result_side
      int unsigned taken    = 0;
      bit          held_off = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            tracker.check_result(rsp_data);
            taken++;
         end
         if (!held_off && taken == 300) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (80) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   initial begin : stimulus
      logic [DELAY_W-1:0] mid_delay;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: first press, focus loss, extreme pads and words, first repeat
      send_frame(frame(0, '1, 1'b1, 0));
      send_frame(frame(0, '1, 1'b0, 31));
      send_frame(frame(15, '1, 1'b0, 31));
      send_frame(frame(15, 32'hAAAA_AAAA, 1'b1, 31));
      send_frame(frame(15, 32'h5555_5555, 1'b1, 0));
      send_frame(frame(15, '1, 1'b1, 1));
      repeat (18) send_frame(frame(3, 32'h8000_0001, 1'b1, 31));

      run_random(200, PADS - 1, 3);

      // Shortest delay, no idling on either side
      settle();
      write_first_delay(8'd0);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(200, 3, 2);

      // Longest delay: steady holds on two pads so repeats start
      settle();
      req_idle_pct = 36;
      rsp_idle_pct = 36;
      write_first_delay(8'd255);
      run_random(600, 1, 0);

      settle();
      mid_delay = DELAY_W'($urandom_range(2, 253));
      write_first_delay(mid_delay);
      run_random(200, PADS - 1, 5);

      settle();
      write_first_delay(8'd1);
      run_random(150, 7, 2);

      // Release one pad through focus loss, then press it again
      send_frame(frame(9, '1, 1'b0, 0));
      send_frame(frame(9, '1, 1'b1, 0));

      settle();
      if (tracker.mismatch_count == 0 && tracker.pending_q.size() == 0)
         $display("[button_edge_and_autorepeat_unit] OK");
      else
         $display("[button_edge_and_autorepeat_unit] ERROR");
      $finish;
   end

   initial begin : watchdog
      #200us;
      $display("[button_edge_and_autorepeat_unit] ERROR");
      $finish;
   end

endmodule
